// ===== rtl/core/fprc_pkg.sv =====
`default_nettype none

package fprc_pkg;

  localparam int WIN_LEN = 17;
  localparam int REP_LEN = 21;
  localparam int HDR_LEN = 8;
  localparam int CELLS   = WIN_LEN - 1;

  localparam logic [7:0]  MAX_REPL_RESET = 8'd32;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;

  localparam logic [7:0] SEARCH_PAT [WIN_LEN] = '{
    8'h00, 8'h0f, "N", "A", "T", "I", "V", "E", "_", "S", "E", "L", "E", "C", "T", "E", "D"
  };

  localparam logic [7:0] REPL_PAT [REP_LEN] = '{
    8'h00, 8'h13, "D", "I", "S", "C", "L", "A", "I", "M", "E", "R", "_",
    "A", "C", "C", "E", "P", "T", "E", "D"
  };

  typedef enum logic [2:0] {
    WIN_HOLD,
    WIN_PUSH,
    WIN_SHIFT,
    WIN_DROP,
    WIN_CLEAR
  } win_op_t;

  typedef struct packed {
    win_op_t    op;
    logic [7:0] data;
  } win_ctrl_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic       head_valid;
    logic       next_valid;
    logic       full;
    logic       match;
  } win_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fprc_cell.sv =====
`default_nettype none

module fprc_cell (
  input  logic             clk,
  input  logic             rst,
  input  fprc_pkg::win_op_t op,
  input  logic [7:0]       new_byte,
  input  logic [7:0]       pat_byte,
  input  logic             prev_valid,
  input  logic [7:0]       next_byte,
  input  logic             next_valid,
  output logic [7:0]       cell_byte,
  output logic             cell_valid,
  output logic             hit
);
  import fprc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      unique case (op)
        WIN_PUSH: begin
          if (!cell_valid && prev_valid) begin
            cell_valid <= 1'b1;
          end
        end
        WIN_SHIFT, WIN_DROP: begin
          cell_valid <= next_valid;
        end
        WIN_CLEAR: begin
          cell_valid <= 1'b0;
        end
        default: begin
          cell_valid <= cell_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      WIN_PUSH: begin
        if (!cell_valid && prev_valid) begin
          cell_byte <= new_byte;
        end
      end
      WIN_SHIFT, WIN_DROP: begin
        cell_byte <= next_byte;
      end
      default: begin
        cell_byte <= cell_byte;
      end
    endcase
  end

  assign hit = cell_valid && (cell_byte == pat_byte);

endmodule

`default_nettype wire

// ===== rtl/core/fprc_window.sv =====
`default_nettype none

module fprc_window (
  input  logic                clk,
  input  logic                rst,
  input  fprc_pkg::win_ctrl_t ctrl,
  output fprc_pkg::win_stat_t stat
);
  import fprc_pkg::*;

  logic [7:0]       cell_bytes [CELLS];
  logic [CELLS-1:0] valids;
  logic [CELLS-1:0] hits;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic       prev_valid;
    logic [7:0] next_byte;
    logic       next_valid;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_inner
      assign prev_valid = valids[i-1];
    end

    if (i == CELLS - 1) begin : g_tail
      assign next_byte  = ctrl.data;
      assign next_valid = (ctrl.op == WIN_SHIFT);
    end else begin : g_body
      assign next_byte  = cell_bytes[i+1];
      assign next_valid = valids[i+1];
    end

    fprc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (ctrl.op),
      .new_byte   (ctrl.data),
      .pat_byte   (SEARCH_PAT[i]),
      .prev_valid (prev_valid),
      .next_byte  (next_byte),
      .next_valid (next_valid),
      .cell_byte  (cell_bytes[i]),
      .cell_valid (valids[i]),
      .hit        (hits[i])
    );
  end

  assign stat.head_byte  = cell_bytes[0];
  assign stat.head_valid = valids[0];
  assign stat.next_valid = valids[1];
  assign stat.full       = valids[CELLS-1];
  assign stat.match      = (&hits) && (ctrl.data == SEARCH_PAT[WIN_LEN-1]);

endmodule

`default_nettype wire

// ===== rtl/core/fixed_pattern_replace_crc32_core.sv =====
`default_nettype none

// Streaming search and replace over a blob with an 8-byte big-endian CRC header.
// Input bytes are taken at one per cycle while in ST_RUN and the output is not
// stalled; the header bytes give no result, and each payload byte gives one
// output transfer once the 16-cell match window is full. A replaced match holds
// the input while its 21 bytes leave, and the last byte of a blob is followed by
// a drain of the bytes left in the window, at most 16. Both come from the single
// output register, which carries one result per cycle unless out_ready holds it,
// and takes a new input byte in the same cycle as the waiting result is taken.
// The final result of each blob carries the new payload CRC, the replacement
// count, the stored CRC check and the short blob flag; a blob that leaves no
// payload byte gives one result with out_has_byte low that carries them.
module fixed_pattern_replace_crc32_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_last,
  output logic [7:0]  replace_count,
  output logic [31:0] new_crc,
  output logic        stored_crc_ok,
  output logic        too_short
);
  import fprc_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_REPL  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t      state, state_next;
  logic [7:0]  max_repl;
  logic [3:0]  header_index, header_index_next;
  logic [63:0] stored_header, stored_header_next;
  logic [31:0] input_crc, input_crc_next;
  logic [31:0] output_crc;
  logic [7:0]  count, count_next;
  logic [4:0]  ridx, ridx_next;
  logic        last_pend, last_pend_next;

  win_ctrl_t   win_ctrl;
  win_stat_t   win_stat;

  logic        adv;
  logic        in_fire;
  logic        emit;
  logic [7:0]  e_byte;
  logic        e_has;
  logic        e_final;
  logic        e_short;
  logic        e_ok;
  logic [7:0]  e_count;
  logic        blob_clear;
  logic [31:0] oc_upd;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = (state == ST_RUN) && adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  fprc_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (win_ctrl),
    .stat (win_stat)
  );

  always_comb begin
    state_next         = state;
    header_index_next  = header_index;
    stored_header_next = stored_header;
    input_crc_next     = input_crc;
    count_next         = count;
    ridx_next          = ridx;
    last_pend_next     = last_pend;
    win_ctrl.op        = WIN_HOLD;
    win_ctrl.data      = in_byte;
    emit               = 1'b0;
    e_byte             = 8'h00;
    e_has              = 1'b0;
    e_final            = 1'b0;
    e_short            = 1'b0;
    e_ok               = stored_header == {32'h0, ~input_crc};
    e_count            = count;
    blob_clear         = 1'b0;

    unique case (state)
      ST_RUN: begin
        if (in_fire) begin
          if (header_index < 4'(HDR_LEN)) begin
            stored_header_next = {stored_header[55:0], in_byte};
            header_index_next  = header_index + 4'd1;
            if (in_last) begin
              emit       = 1'b1;
              e_final    = 1'b1;
              e_short    = header_index_next < 4'(HDR_LEN);
              e_ok       = !e_short && (stored_header_next == {32'h0, ~input_crc});
              e_count    = 8'h00;
              blob_clear = 1'b1;
            end
          end else begin
            input_crc_next = crc_byte(input_crc, in_byte);
            if (!win_stat.full) begin
              win_ctrl.op = WIN_PUSH;
              if (in_last) begin
                state_next = ST_FLUSH;
              end
            end else if (win_stat.match && (count < max_repl)) begin
              win_ctrl.op    = WIN_CLEAR;
              count_next     = count + 8'd1;
              emit           = 1'b1;
              e_byte         = REPL_PAT[0];
              e_has          = 1'b1;
              e_count        = count_next;
              ridx_next      = 5'd1;
              last_pend_next = in_last;
              state_next     = ST_REPL;
            end else begin
              win_ctrl.op = WIN_SHIFT;
              emit        = 1'b1;
              e_byte      = win_stat.head_byte;
              e_has       = 1'b1;
              if (in_last) begin
                state_next = ST_FLUSH;
              end
            end
          end
        end
      end
      ST_REPL: begin
        if (adv) begin
          emit      = 1'b1;
          e_byte    = REPL_PAT[ridx];
          e_has     = 1'b1;
          ridx_next = ridx + 5'd1;
          if (ridx == 5'(REP_LEN - 1)) begin
            state_next = ST_RUN;
            if (last_pend) begin
              e_final    = 1'b1;
              blob_clear = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          win_ctrl.op = WIN_DROP;
          emit        = 1'b1;
          e_byte      = win_stat.head_byte;
          e_has       = 1'b1;
          if (!win_stat.next_valid) begin
            state_next = ST_RUN;
            e_final    = 1'b1;
            blob_clear = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign oc_upd = crc_byte(output_crc, e_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      max_repl      <= MAX_REPL_RESET;
      header_index  <= 4'd0;
      stored_header <= 64'h0;
      input_crc     <= CRC_INIT;
      output_crc    <= CRC_INIT;
      count         <= 8'h00;
      ridx          <= 5'd0;
      last_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      ridx      <= ridx_next;
      last_pend <= last_pend_next;
      if (cfg_valid && cfg_ready) begin
        max_repl <= cfg_data;
      end
      if (blob_clear) begin
        header_index  <= 4'd0;
        stored_header <= 64'h0;
        input_crc     <= CRC_INIT;
        output_crc    <= CRC_INIT;
        count         <= 8'h00;
      end else begin
        header_index  <= header_index_next;
        stored_header <= stored_header_next;
        input_crc     <= input_crc_next;
        count         <= count_next;
        if (emit && e_has) begin
          output_crc <= oc_upd;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= e_byte;
      out_has_byte  <= e_has;
      out_last      <= e_final;
      replace_count <= e_count;
      new_crc       <= (e_final && e_has) ? ~oc_upd : 32'h0;
      stored_crc_ok <= e_final && e_ok;
      too_short     <= e_final && e_short;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPL) |-> !win_stat.head_valid)
    else $error("window not empty while a replacement is sent");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> win_stat.head_valid)
    else $error("window drained with no byte left to send");

  assert property (@(posedge clk) disable iff (rst)
    (emit && e_final) |=> (header_index == 4'd0 && count == 8'h00
                           && output_crc == CRC_INIT && state == ST_RUN))
    else $error("blob state not cleared after the final result");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_has_byte) |-> out_last)
    else $error("result without a byte that is not the final one");

endmodule

`default_nettype wire
